[sv/vertex_linear_blend_skinning_unit_defines.svh]
// assertion macros shared by the skinning unit
`ifndef VERTEX_LINEAR_BLEND_SKINNING_UNIT_DEFINES_SVH
`define VERTEX_LINEAR_BLEND_SKINNING_UNIT_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define LBS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define LBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/lbs_pkg.sv]
// shared constants, types and helpers of the skinning unit
package lbs_pkg;

	localparam int NUM_BONES    = 128;
	localparam int FRAC_BITS    = 16;
	localparam int NUM_LANES    = 4;
	localparam int BONE_W       = $clog2(NUM_BONES);
	localparam int ADDR_W       = 11;
	localparam int JOINT_W      = 7;
	localparam int WEIGHT_W     = 16;
	localparam int WEIGHT_FRAC  = 15;
	localparam int NUM_BANKS    = 12;
	localparam int NRM_W        = 18;
	localparam int NRM_ONE      = 65536;
	localparam int LANE_LAT     = 5;
	localparam int DIV_STAGES   = 35;
	localparam int SQRT_STAGES  = 17;
	localparam int NORM_LAT     = 3 + DIV_STAGES + SQRT_STAGES;
	localparam int TOTAL_LAT    = LANE_LAT + 1 + NORM_LAT;
	localparam int IN_BITS      = ADDR_W + 32 + 6 * 32 + 4 * JOINT_W + 4 * WEIGHT_W;
	localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS     = 3 * 32 + 3 * NRM_W;
	localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

	typedef logic signed [31:0]       word_t;
	typedef logic signed [48:0]       wprod_t;
	typedef logic signed [65:0]       wide_t;
	typedef logic signed [NRM_W-1:0]  nrm_t;
	typedef word_t                    vec3_t [3];
	typedef wprod_t                   wvec3_t [3];
	typedef nrm_t                     nvec3_t [3];

	typedef enum logic {
		CMD_PALETTE = 1'b0,
		CMD_VERTEX  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		word_t             data;
	} pal_wr_t;

	function automatic word_t sat32(input wide_t v);
		word_t r;
		if (v[65:31] == '0 || v[65:31] == '1) begin
			r = $signed(v[31:0]);
		end else if (v[65]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

endpackage

[sv/lbs_lane.sv]
// one influence lane: bone matrix banks, row transforms and weighting
module lbs_lane import lbs_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  pal_wr_t            wr,
	input  logic [JOINT_W-1:0] joint,
	input  logic [WEIGHT_W-1:0] weight,
	input  vec3_t              pos,
	input  vec3_t              nrm,
	output wvec3_t             wpos,
	output wvec3_t             wnrm
);

	localparam wide_t RND_F = wide_t'(1) <<< (FRAC_BITS - 1);

	logic [BONE_W-1:0] wr_bone;
	logic [BONE_W-1:0] rd_bone;
	logic [3:0]        wr_bank;
	logic              wr_ok;
	logic              bone_ok;

	// only rows 0..2 of each column are ever used, row 3 is dropped
	assign wr_bone = wr.addr[BONE_W+3:4];
	assign wr_bank = 4'(wr.addr[3:2]) * 4'd3 + 4'(wr.addr[1:0]);
	assign wr_ok   = ({1'b0, wr.addr} < (ADDR_W + 1)'(NUM_BONES * 16)) && (wr.addr[1:0] != 2'd3);
	assign rd_bone = joint[BONE_W-1:0];
	assign bone_ok = {1'b0, joint} < (JOINT_W + 1)'(NUM_BONES);

	word_t mat_s1 [NUM_BANKS];

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		word_t bank_mem [NUM_BONES];

		always_ff @(posedge clk) begin
			if (wr.en && wr_ok && wr_bank == 4'(b)) begin
				bank_mem[wr_bone] <= wr.data;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mat_s1[b] <= bank_mem[rd_bone];
			end
		end
	end

	logic                bone_ok_s1;
	vec3_t               pos_s1, nrm_s1;
	logic [WEIGHT_W-1:0] w_s1, w_s2, w_s3, w_s4;
	logic signed [63:0]  pp_s2 [3][3];
	logic signed [63:0]  pn_s2 [3][3];
	word_t               pt_s2 [3];
	wide_t               sp_s3 [3];
	wide_t               sn_s3 [3];
	word_t               xp_s4 [3];
	word_t               xn_s4 [3];
	wprod_t              wp_s5 [3];
	wprod_t              wn_s5 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			bone_ok_s1 <= bone_ok;
			pos_s1     <= pos;
			nrm_s1     <= nrm;
			w_s1       <= weight;
			w_s2       <= w_s1;
			w_s3       <= w_s2;
			w_s4       <= w_s3;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					pp_s2[r][c] <= bone_ok_s1 ? mat_s1[c*3+r] * pos_s1[c] : 64'sd0;
					pn_s2[r][c] <= bone_ok_s1 ? mat_s1[c*3+r] * nrm_s1[c] : 64'sd0;
				end
				pt_s2[r] <= bone_ok_s1 ? mat_s1[9+r] : 32'sd0;
				// point gets the translation column, direction does not
				sp_s3[r] <= wide_t'(pp_s2[r][0]) + wide_t'(pp_s2[r][1]) + wide_t'(pp_s2[r][2])
					+ (wide_t'(pt_s2[r]) <<< FRAC_BITS);
				sn_s3[r] <= wide_t'(pn_s2[r][0]) + wide_t'(pn_s2[r][1]) + wide_t'(pn_s2[r][2]);
				xp_s4[r] <= sat32((sp_s3[r] + RND_F) >>> FRAC_BITS);
				xn_s4[r] <= sat32((sn_s3[r] + RND_F) >>> FRAC_BITS);
				wp_s5[r] <= xp_s4[r] * $signed({1'b0, w_s4});
				wn_s5[r] <= xn_s4[r] * $signed({1'b0, w_s4});
			end
		end
	end

	assign wpos = wp_s5;
	assign wnrm = wn_s5;

endmodule

[sv/lbs_norm.sv]
// pipelined normal normalizer: prescale, squared length, divide, root
module lbs_norm import lbs_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  vec3_t  vec,
	output nvec3_t nrm_out
);

	localparam logic [17:0] M_MAX = 18'(NRM_ONE);

	logic [31:0] mag [3];
	logic [31:0] all_or;
	logic [4:0]  shamt;

	always_comb begin
		all_or = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = vec[i][31] ? 32'(-vec[i]) : 32'(vec[i]);
			all_or = all_or | mag[i];
		end
		// shift so every magnitude lands below 2^15
		shamt = '0;
		for (int b = 15; b < 32; b++) begin
			if (all_or[b]) begin
				shamt = 5'(b - 14);
			end
		end
	end

	logic [31:0] mag_s1 [3];
	logic [4:0]  shamt_s1;
	logic [29:0] sq_s2 [3];
	logic [29:0] sq_s3 [3];
	logic [31:0] len_s3;
	logic [2:0]  neg_s [NORM_LAT];
	logic        zero_s [NORM_LAT];
	logic [14:0] msh [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			msh[i] = 15'(mag_s1[i] >> shamt_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			shamt_s1 <= shamt;
			neg_s[0] <= {vec[2][31], vec[1][31], vec[0][31]};
			zero_s[0] <= (all_or == '0);
			for (int j = 1; j < NORM_LAT; j++) begin
				neg_s[j]  <= neg_s[j-1];
				zero_s[j] <= zero_s[j-1];
			end
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag[i];
				sq_s2[i]  <= 30'(msh[i]) * 30'(msh[i]);
				sq_s3[i]  <= sq_s2[i];
			end
			len_s3 <= 32'(sq_s2[0]) + 32'(sq_s2[1]) + 32'(sq_s2[2]);
		end
	end

	// restoring divider, one quotient bit per stage: q = (sq << 34) / len
	logic [31:0]           div_rem_s  [DIV_STAGES][3];
	logic [DIV_STAGES-1:0] div_quo_s  [DIV_STAGES][3];
	logic [31:0]           div_len_s  [DIV_STAGES];
	logic [31:0]           div_rem_nx [DIV_STAGES][3];
	logic [DIV_STAGES-1:0] div_quo_nx [DIV_STAGES][3];

	always_comb begin
		logic [32:0]           trial;
		logic [31:0]           len_in;
		logic [DIV_STAGES-1:0] quo_in;
		logic                  take;
		for (int j = 0; j < DIV_STAGES; j++) begin
			for (int i = 0; i < 3; i++) begin
				if (j == 0) begin
					trial  = 33'(sq_s3[i]);
					len_in = len_s3;
					quo_in = '0;
				end else begin
					trial  = {div_rem_s[j-1][i], 1'b0};
					len_in = div_len_s[j-1];
					quo_in = div_quo_s[j-1][i];
				end
				take = trial >= {1'b0, len_in};
				div_rem_nx[j][i] = take ? 32'(trial - {1'b0, len_in}) : trial[31:0];
				div_quo_nx[j][i] = {quo_in[DIV_STAGES-2:0], take};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_len_s[0] <= len_s3;
			for (int j = 1; j < DIV_STAGES; j++) begin
				div_len_s[j] <= div_len_s[j-1];
			end
			div_rem_s <= div_rem_nx;
			div_quo_s <= div_quo_nx;
		end
	end

	// bit-serial root: largest m <= 1.0 with (2m-1)^2 <= q, square kept incrementally
	logic [16:0]           sqm_s  [SQRT_STAGES][3];
	logic signed [18:0]    sqt_s  [SQRT_STAGES][3];
	logic [35:0]           sqv_s  [SQRT_STAGES][3];
	logic [DIV_STAGES-1:0] sqq_s  [SQRT_STAGES][3];
	logic [16:0]           sqm_nx [SQRT_STAGES][3];
	logic signed [18:0]    sqt_nx [SQRT_STAGES][3];
	logic [35:0]           sqv_nx [SQRT_STAGES][3];
	logic [DIV_STAGES-1:0] sqq_nx [SQRT_STAGES][3];

	always_comb begin
		int                    k;
		logic [16:0]           m_in;
		logic signed [18:0]    t_in;
		logic [35:0]           v_in;
		logic [DIV_STAGES-1:0] q_in;
		logic [17:0]           m_try;
		logic signed [18:0]    t_try;
		logic [39:0]           v_try;
		logic                  take;
		for (int j = 0; j < SQRT_STAGES; j++) begin
			for (int i = 0; i < 3; i++) begin
				k = SQRT_STAGES - 1 - j;
				if (j == 0) begin
					m_in = '0;
					t_in = -19'sd1;
					v_in = 36'd1;
					q_in = div_quo_s[DIV_STAGES-1][i];
				end else begin
					m_in = sqm_s[j-1][i];
					t_in = sqt_s[j-1][i];
					v_in = sqv_s[j-1][i];
					q_in = sqq_s[j-1][i];
				end
				m_try = 18'(m_in) + (18'd1 << k);
				t_try = t_in + (19'sd2 <<< k);
				v_try = 40'(v_in) + (40'(t_in) << (k + 2)) + (40'd1 << (2 * k + 2));
				take  = (m_try <= M_MAX) && (v_try <= 40'(q_in));
				sqm_nx[j][i] = take ? m_try[16:0] : m_in;
				sqt_nx[j][i] = take ? t_try : t_in;
				sqv_nx[j][i] = take ? v_try[35:0] : v_in;
				sqq_nx[j][i] = q_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqm_s <= sqm_nx;
			sqt_s <= sqt_nx;
			sqv_s <= sqv_nx;
			sqq_s <= sqq_nx;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (zero_s[NORM_LAT-1]) begin
				nrm_out[i] = '0;
			end else if (neg_s[NORM_LAT-1][i]) begin
				nrm_out[i] = -$signed({1'b0, sqm_s[SQRT_STAGES-1][i]});
			end else begin
				nrm_out[i] = $signed({1'b0, sqm_s[SQRT_STAGES-1][i]});
			end
		end
	end

endmodule

[sv/vertex_linear_blend_skinning_unit.sv]
// top level: stream ports, palette write fan-out, lane merge, normalizer, output skid
// throughput: one beat per cycle while the skid entry is empty, palette writes and vertices alike;
// a palette write gives no result
// the rate is set by four parallel influence lanes, each with its own copy of the palette
// banks, and a fully pipelined divider and root in the normalizer
// reset clears all valid bits and sets normals_present to 1; palette contents are not cleared
module vertex_linear_blend_skinning_unit import lbs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// slave side
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// palette_addr, palette_value, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
	// joints_packed, weights_packed (low bit up), zero padded
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// cmd
	input  logic                   s_tuser,
	// master side
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z (low bit up), zero padded
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// configuration
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	`include "vertex_linear_blend_skinning_unit_defines.svh"

	typedef enum logic {
		REG_NORMALS = 1'b0
	} reg_idx_t;

	localparam int OFS_ADDR   = 0;
	localparam int OFS_VALUE  = OFS_ADDR + ADDR_W;
	localparam int OFS_POS    = OFS_VALUE + 32;
	localparam int OFS_NRM    = OFS_POS + 3 * 32;
	localparam int OFS_JOINT  = OFS_NRM + 3 * 32;
	localparam int OFS_WEIGHT = OFS_JOINT + 4 * JOINT_W;
	localparam wide_t RND_W   = wide_t'(1) <<< (WEIGHT_FRAC - 1);

	// ---------------- configuration register ----------------
	logic     normals_present_q;
	logic     cfg_wr;
	reg_idx_t reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normals_present_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_NORMALS: normals_present_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_NORMALS: prdata = {31'd0, normals_present_q};
			default:     prdata = '0;
		endcase
	end

	// ---------------- input side ----------------
	// the whole pipeline advances together; it freezes only while the skid entry is full
	logic    en;
	logic    in_beat;
	logic    in_vertex;
	cmd_t    cmd;
	pal_wr_t pal_wr;
	vec3_t   in_pos, in_nrm;

	assign cmd       = cmd_t'(s_tuser);
	assign s_tready  = en;
	assign in_beat   = s_tvalid & s_tready;
	assign in_vertex = in_beat && (cmd == CMD_VERTEX);

	assign pal_wr.en   = in_beat && (cmd == CMD_PALETTE);
	assign pal_wr.addr = s_tdata[OFS_ADDR +: ADDR_W];
	assign pal_wr.data = $signed(s_tdata[OFS_VALUE +: 32]);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			in_pos[c] = $signed(s_tdata[OFS_POS + 32*c +: 32]);
			in_nrm[c] = $signed(s_tdata[OFS_NRM + 32*c +: 32]);
		end
	end

	// ---------------- influence lanes ----------------
	// each lane holds a full palette copy so all four bones are read in the same cycle
	wprod_t lane_wpos [NUM_LANES][3];
	wprod_t lane_wnrm [NUM_LANES][3];

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		lbs_lane u_lane (
			.clk    (clk),
			.en     (en),
			.wr     (pal_wr),
			.joint  (s_tdata[OFS_JOINT + JOINT_W*l +: JOINT_W]),
			.weight (s_tdata[OFS_WEIGHT + WEIGHT_W*l +: WEIGHT_W]),
			.pos    (in_pos),
			.nrm    (in_nrm),
			.wpos   (lane_wpos[l]),
			.wnrm   (lane_wnrm[l])
		);
	end

	// ---------------- lane merge ----------------
	// exact sum of the weighted rows, rounded half up at the weight point, saturated
	wide_t acc_pos [3];
	wide_t acc_nrm [3];
	word_t pos_s6 [3];
	vec3_t nrm_s6;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc_pos[r] = '0;
			acc_nrm[r] = '0;
			for (int l = 0; l < NUM_LANES; l++) begin
				acc_pos[r] = acc_pos[r] + wide_t'(lane_wpos[l][r]);
				acc_nrm[r] = acc_nrm[r] + wide_t'(lane_wnrm[l][r]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				pos_s6[r] <= sat32((acc_pos[r] + RND_W) >>> WEIGHT_FRAC);
				nrm_s6[r] <= sat32((acc_nrm[r] + RND_W) >>> WEIGHT_FRAC);
			end
		end
	end

	// ---------------- normal unit and position delay line ----------------
	nvec3_t norm_out;

	lbs_norm u_norm (
		.clk     (clk),
		.en      (en),
		.vec     (nrm_s6),
		.nrm_out (norm_out)
	);

	// positions wait alongside the normalizer
	word_t pos_d [NORM_LAT][3];

	always_ff @(posedge clk) begin
		if (en) begin
			pos_d[0] <= pos_s6;
			for (int j = 1; j < NORM_LAT; j++) begin
				pos_d[j] <= pos_d[j-1];
			end
		end
	end

	// one valid bit per pipeline stage, vertices only
	logic [TOTAL_LAT-1:0] v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[TOTAL_LAT-2:0], in_vertex};
		end
	end

	// ---------------- output register and skid entry ----------------
	logic                   fin_valid;
	logic [OUT_TDATA_W-1:0] fin_data;
	nvec3_t                 nrm_g;
	logic                   out_valid_q, skid_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q, skid_data_q;

	assign fin_valid = v_s[TOTAL_LAT-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nrm_g[i] = normals_present_q ? norm_out[i] : '0;
		end
		fin_data = OUT_TDATA_W'({nrm_g[2], nrm_g[1], nrm_g[0],
			pos_d[NORM_LAT-1][2], pos_d[NORM_LAT-1][1], pos_d[NORM_LAT-1][0]});
	end

	assign en = ~skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_tready) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= fin_valid;
		end else if (fin_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_tready) begin
				out_data_q <= skid_data_q;
			end
		end else if (!out_valid_q || m_tready) begin
			if (fin_valid) begin
				out_data_q <= fin_data;
			end
		end else if (fin_valid) begin
			skid_data_q <= fin_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// ---------------- checks ----------------
	`LBS_ASSERT(a_skid_has_out, clk, arst_n, skid_valid_q |-> out_valid_q, "skid full with empty output")
	`LBS_ASSERT_NEXT(a_skid_fill, clk, arst_n, !skid_valid_q && out_valid_q && !m_tready && fin_valid, skid_valid_q, "stalled result not caught by skid")
	`LBS_ASSERT_NEXT(a_palette_no_result, clk, arst_n, in_beat && cmd == CMD_PALETTE, !v_s[0], "palette write entered the vertex pipe")
	`LBS_ASSERT_NEXT(a_hold_on_stall, clk, arst_n, !en, fin_valid == $past(fin_valid), "pipeline moved while frozen")

endmodule

[test/vertex_linear_blend_skinning_unit_tb.sv]
// self-checking testbench for the linear blend skinning unit
module vertex_linear_blend_skinning_unit_tb;
	import lbs_pkg::*;

	// stream beat as the driver sees it
	typedef struct {
		logic        cmd;
		logic [10:0] addr;
		logic [31:0] value;
		logic [31:0] pos [3];
		logic [31:0] nrm [3];
		logic [27:0] joints;
		logic [63:0] weights;
	} vbeat_t;

	typedef struct {
		logic [31:0] p [3];
		logic [17:0] n [3];
	} skinned_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	vertex_linear_blend_skinning_unit dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic signed [31:0] palette_copy [NUM_BONES*16];
	bit nrm_on = 1'b1;

	vbeat_t pending_beats [$];
	skinned_t skinned_q [$];
	int errors = 0;
	int idle_cycles = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit hold_off = 1'b0;

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// one row of one bone matrix applied to a vector
	function automatic longint bone_row(int b, int row, longint v [3], bit point);
		longint hi = 0, lo = 0, p, h, x;
		for (int c = 0; c < 4; c++) begin
			if (c == 3 && !point) break;
			if (b >= NUM_BONES) p = 0;
			else if (c == 3) p = longint'(palette_copy[b*16+12+row]) <<< FRAC_BITS;
			else p = longint'(palette_copy[b*16+c*4+row]) * v[c];
			h = shr(p, 2);
			hi += h;
			lo += p - h * 4;
		end
		x = lo + (64'sd1 <<< (FRAC_BITS - 1));
		return clip32(shr(hi + shr(x, 2), FRAC_BITS - 2));
	endfunction

	function automatic void blend(vbeat_t t, bit point, logic [31:0] src [3],
			output longint r [3]);
		longint v [3];
		longint acc;
		int b;
		for (int i = 0; i < 3; i++) v[i] = longint'($signed(src[i]));
		for (int row = 0; row < 3; row++) begin
			acc = 0;
			for (int j = 0; j < 4; j++) begin
				b = (t.joints >> (7*j)) & 7'h7f;
				acc += bone_row(b, row, v, point) * longint'((t.weights >> (16*j)) & 16'hffff);
			end
			r[row] = clip32(shr(acc + (64'sd1 <<< 14), 15));
		end
	endfunction

	function automatic skinned_t predict_skin(vbeat_t t);
		skinned_t o;
		longint sp [3], sn [3];
		longint unsigned mag [3], mx, len2, q, tt;
		longint unsigned lo, hi, mid;
		int s;
		blend(t, 1'b1, t.pos, sp);
		for (int i = 0; i < 3; i++) begin
			o.p[i] = sp[i][31:0];
			o.n[i] = '0;
		end
		if (nrm_on) begin
			blend(t, 1'b0, t.nrm, sn);
			mx = 0;
			for (int i = 0; i < 3; i++) begin
				mag[i] = sn[i] < 0 ? -sn[i] : sn[i];
				if (mag[i] > mx) mx = mag[i];
			end
			if (mx != 0) begin
				s = 0;
				while ((mx >> s) >= 32768) s++;
				len2 = 0;
				for (int i = 0; i < 3; i++) begin
					mag[i] = mag[i] >> s;
					len2 += mag[i] * mag[i];
				end
				for (int i = 0; i < 3; i++) begin
					q = ((mag[i] * mag[i]) << 34) / len2;
					lo = 0;
					hi = 65536;
					while (lo < hi) begin
						mid = (lo + hi + 1) / 2;
						tt = 2 * mid - 1;
						if (tt * tt <= q) lo = mid; else hi = mid - 1;
					end
					o.n[i] = sn[i] < 0 ? 18'(-lo) : 18'(lo);
				end
			end
		end
		return o;
	endfunction

	function automatic logic [IN_TDATA_W-1:0] pack_beat(vbeat_t t);
		logic [IN_TDATA_W-1:0] d = '0;
		d[10:0] = t.addr;
		d[42:11] = t.value;
		for (int i = 0; i < 3; i++) begin
			d[43+32*i +: 32] = t.pos[i];
			d[139+32*i +: 32] = t.nrm[i];
		end
		d[235 +: 28] = t.joints;
		d[263 +: 64] = t.weights;
		return d;
	endfunction

	// driver: prediction is done at acceptance so palette order matches the block
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (s_tuser == CMD_PALETTE) begin
					if (s_tdata[10:0] < NUM_BONES*16)
						palette_copy[s_tdata[10:0]] <= $signed(s_tdata[42:11]);
				end
			end
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left > 0 || hold_off || pending_beats.size() == 0) begin
					s_tvalid <= 1'b0;
					if (gap_left > 0) gap_left <= gap_left - 1;
				end else begin
					vbeat_t t;
					t = pending_beats.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= t.cmd;
					s_tdata <= pack_beat(t);
					if ($urandom_range(0, 3) == 0)
						gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
							: $urandom_range(0, 2);
				end
			end
		end
	end

	// monitor with a random receiver stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				skinned_t a;
				for (int i = 0; i < 3; i++) begin
					a.p[i] = m_tdata[32*i +: 32];
					a.n[i] = m_tdata[96+18*i +: 18];
				end
				if (skinned_q.size() == 0) begin
					$error("out beat with nothing expected");
					errors++;
				end else begin
					skinned_t e;
					e = skinned_q.pop_front();
					for (int i = 0; i < 3; i++) begin
						if (a.p[i] !== e.p[i]) begin
							$error("out_pos[%0d] expected %h actual %h", i, e.p[i], a.p[i]);
							errors++;
						end
						if (a.n[i] !== e.n[i]) begin
							$error("out_nrm[%0d] expected %h actual %h", i, e.n[i], a.n[i]);
							errors++;
						end
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
					: $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// expectations are built when the vertex beat is accepted, after palette writes before it
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready && s_tuser == CMD_VERTEX) begin
			vbeat_t t;
			t.cmd = 1'b1;
			for (int i = 0; i < 3; i++) begin
				t.pos[i] = s_tdata[43+32*i +: 32];
				t.nrm[i] = s_tdata[139+32*i +: 32];
			end
			t.joints = s_tdata[235 +: 28];
			t.weights = s_tdata[263 +: 64];
			skinned_q.push_back(predict_skin(t));
		end
	end

	// watchdog: cycles in which no beat moves on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 20000) begin
				$display("FAIL vertex_linear_blend_skinning_unit");
				$finish;
			end
		end
	end

	function automatic logic [31:0] rnd32();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
			3: return $signed($urandom_range(0, 262143)) - 131072;
			default: return $urandom;
		endcase
	endfunction

	// only joints whose bone was fully written
	function automatic logic [6:0] rnd_joint(int base, int nb);
		return 7'($urandom_range(base, base + nb - 1));
	endfunction

	function automatic vbeat_t mk_vertex(int base, int nb, bit wild);
		vbeat_t t;
		t.cmd = 1'b1;
		t.addr = $urandom;
		t.value = $urandom;
		for (int i = 0; i < 3; i++) begin
			t.pos[i] = wild ? rnd32() : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
			t.nrm[i] = wild ? rnd32() : 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
		end
		t.joints = {rnd_joint(base, nb), rnd_joint(base, nb), rnd_joint(base, nb),
			rnd_joint(base, nb)};
		t.weights = {$urandom, $urandom};
		return t;
	endfunction

	function automatic vbeat_t mk_pal(int a, logic [31:0] v);
		vbeat_t t;
		t.cmd = 1'b0;
		t.addr = a;
		t.value = v;
		for (int i = 0; i < 3; i++) begin
			t.pos[i] = $urandom;
			t.nrm[i] = $urandom;
		end
		t.joints = $urandom;
		t.weights = {$urandom, $urandom};
		return t;
	endfunction

	task automatic wait_drain();
		while (pending_beats.size() != 0 || s_tvalid || skinned_q.size() != 0)
			@(posedge clk);
		repeat (TOTAL_LAT + 10) @(posedge clk);
	endtask

	task automatic apb_write(logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'd0;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		nrm_on = v[0];
	endtask

	initial begin
		vbeat_t t;
		int nb;
		int base;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// directed: identity and extreme bones, then extreme vertices
		for (int k = 0; k < 16; k++) pending_beats.push_back(mk_pal(k, (k % 5 == 0) ? 32'h10000 : 0));
		for (int k = 16; k < 32; k++) pending_beats.push_back(mk_pal(k, k[0] ? 32'h7fffffff : 32'h80000000));
		pending_beats.push_back(mk_pal(2047, 32'hdeadbeef));  // row 3 of the last bone, never read
		t = mk_vertex(0, 2, 1'b1);
		t.pos = '{32'h7fffffff, 32'h80000000, 32'h00010000};
		t.nrm = '{0, 0, 0};                                     // zero-length normal
		t.joints = {7'd0, 7'd0, 7'd1, 7'd0};
		t.weights = {16'hffff, 16'h0, 16'hffff, 16'h8000};
		pending_beats.push_back(t);
		t.nrm = '{32'h7fffffff, 32'h80000000, 32'h1};
		t.joints = {7'd1, 7'd0, 7'd1, 7'd1};                   // extreme normal on saturated bones
		pending_beats.push_back(t);
		for (int k = 0; k < 4; k++) pending_beats.push_back(mk_vertex(0, 2, 1'b1));
		wait_drain();
		// pressure: nothing sent until the pipeline empties
		hold_off = 1'b1;
		wait_drain();
		hold_off = 1'b0;
		for (int phase = 0; phase < 4; phase++) begin
			apb_write(phase == 1 ? 32'hfffffffe : {$urandom_range(0, 1) ? 32'h0 : 32'hffffffff});
			apb_write(phase[0] ? 32'h0 : 32'h1);
			base = (phase == 3) ? NUM_BONES - 8 : 0;
			nb = (phase == 3) ? 8 : 2 + phase * 2;
			for (int a = base * 16; a < (base + nb) * 16; a++)
				pending_beats.push_back(mk_pal(a, $urandom_range(0, 3) == 0 ? rnd32()
					: 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16))));
			for (int k = 0; k < 170; k++) begin
				if ($urandom_range(0, 9) == 0)
					pending_beats.push_back(mk_pal($urandom_range(0, 2047), rnd32()));
				else
					pending_beats.push_back(mk_vertex(base, nb, $urandom_range(0, 3) == 0));
			end
			wait_drain();
		end
		if (errors == 0) begin
			$display("PASS vertex_linear_blend_skinning_unit");
		end else begin
			$display("FAIL vertex_linear_blend_skinning_unit");
		end
		$finish;
	end
endmodule

[filelist.f]
+incdir+sv
sv/lbs_pkg.sv
sv/lbs_lane.sv
sv/lbs_norm.sv
sv/vertex_linear_blend_skinning_unit.sv
test/vertex_linear_blend_skinning_unit_tb.sv
